// ===== design/krt_pkg.sv =====
package krt_pkg;

	localparam int KeyWidth   = 32;
	localparam int ValueWidth = 16;
	localparam int CountWidth = 7;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SEARCH = 3'd1,
		OP_UPDATE = 3'd2,
		OP_DELETE = 3'd3,
		OP_LIST   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// what the datapath loads into the result register
	typedef enum logic [2:0] {
		RES_ADD,
		RES_FULL,
		RES_MISS,
		RES_EMPTY,
		RES_READ,
		RES_UPD,
		RES_DEL
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SCAN,
		S_SHIFT,
		S_LIST
	} state_t;

	typedef struct packed {
		logic signed [KeyWidth-1:0] key;
		logic [ValueWidth-1:0]      value;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic wr_add;
		logic wr_upd;
		logic wr_shift;
		logic dec;
		logic emit;
		res_t res;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic rd_more;
		logic vld;
		logic hit;
		logic is_last;
	} stat_t;

endpackage

// ===== design/keyed_record_table.sv =====
// Keyed table of up to DEPTH (key, value) entries in insertion order, held in a
// single-port-write, single-port-read memory that is walked one entry per clock.
// A word is taken when start is high and busy is low; results then appear on
// strobe, one cycle each, and cannot be held off. Add registers its result from
// the add state. Search and update walk the entries from the first and register
// the result at the first match, or at the end of the walk on a miss; an empty
// table reports the miss at once. Delete gives its result at the same point and
// then stays busy while the later entries move down. List gives one word per
// cycle, count words, or a single empty report on an empty table. Unused op
// codes are taken and dropped with no result. No clearing pass follows reset.
module keyed_record_table import krt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 op,
	input  logic signed [KeyWidth-1:0] key,
	input  logic [ValueWidth-1:0]      value,
	output logic                       strobe,
	output logic [1:0]                 status,
	output logic signed [KeyWidth-1:0] found_key,
	output logic [ValueWidth-1:0]      found_value,
	output logic [CountWidth-1:0]      entry_count,
	output logic                       last
);

	cmd_t  cmd;
	stat_t st;

	krt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	krt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key         (key),
		.value       (value),
		.st          (st),
		.strobe      (strobe),
		.status      (status),
		.found_key   (found_key),
		.found_value (found_value),
		.entry_count (entry_count),
		.last        (last)
	);

endmodule

// ===== design/krt_ctrl.sv =====
module krt_ctrl import krt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] op,
	input  stat_t      st,
	output cmd_t       cmd,
	output logic       busy
);

	state_t     state_q, state_d;
	logic [2:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ADD;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				op_q <= op;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (op)
						OP_ADD:                          state_d = S_ADD;
						OP_SEARCH, OP_UPDATE, OP_DELETE: state_d = S_SCAN;
						OP_LIST:                         state_d = S_LIST;
						default:                         state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: state_d = S_IDLE;
			S_SCAN: begin
				if (st.hit) begin
					state_d = (op_q == OP_DELETE) ? S_SHIFT : S_IDLE;
				end else if (!st.rd_more && !st.vld) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT, S_LIST: begin
				if (!st.rd_more && !st.vld) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		cmd.res = RES_MISS;
		cmd.last = 1'b1;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.load = start;
			S_ADD: begin
				cmd.emit = 1'b1;
				if (st.full) begin
					cmd.res = RES_FULL;
				end else begin
					cmd.res    = RES_ADD;
					cmd.wr_add = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.rd_en = st.rd_more;
				if (st.hit) begin
					cmd.emit = 1'b1;
					case (op_q)
						OP_UPDATE: begin
							cmd.res    = RES_UPD;
							cmd.wr_upd = 1'b1;
						end
						OP_DELETE: cmd.res = RES_DEL;
						default:   cmd.res = RES_READ;
					endcase
				end else if (!st.rd_more && !st.vld) begin
					cmd.emit = 1'b1;
				end
			end
			S_SHIFT: begin
				// move each later entry down one place, drop count at the end
				cmd.rd_en    = st.rd_more;
				cmd.wr_shift = st.vld;
				cmd.dec      = !st.rd_more && !st.vld;
			end
			S_LIST: begin
				cmd.rd_en = st.rd_more;
				if (st.vld) begin
					cmd.emit = 1'b1;
					cmd.res  = RES_READ;
					cmd.last = st.is_last;
				end else if (!st.rd_more && st.empty) begin
					cmd.emit = 1'b1;
					cmd.res  = RES_EMPTY;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== design/krt_dp.sv =====
module krt_dp import krt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	input  logic signed [KeyWidth-1:0]   key,
	input  logic [ValueWidth-1:0]        value,
	output stat_t                        st,
	output logic                         strobe,
	output logic [1:0]                   status,
	output logic signed [KeyWidth-1:0]   found_key,
	output logic [ValueWidth-1:0]        found_value,
	output logic [CountWidth-1:0]        entry_count,
	output logic                         last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t mem [DEPTH];

	logic signed [KeyWidth-1:0] key_q;
	logic [ValueWidth-1:0]      value_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              idx_q;

	entry_t        rd_data_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          rd_vld_s1;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	logic [CW-1:0] count_res;

	assign st.full    = (count_q == CW'(DEPTH));
	assign st.empty   = (count_q == '0);
	assign st.rd_more = (idx_q < count_q);
	assign st.vld     = rd_vld_s1;
	assign st.hit     = rd_vld_s1 && (rd_data_s1.key == key_q);
	assign st.is_last = (CW'(rd_idx_s1) == count_q - CW'(1));

	always_comb begin
		wr_en   = cmd.wr_add || cmd.wr_upd || cmd.wr_shift;
		wr_addr = count_q[AW-1:0];
		wr_data = '{key: key_q, value: value_q};
		if (cmd.wr_upd) begin
			wr_addr = rd_idx_s1;
			wr_data = '{key: rd_data_s1.key, value: value_q};
		end else if (cmd.wr_shift) begin
			wr_addr = AW'(rd_idx_s1 - AW'(1));
			wr_data = rd_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		if (cmd.load) begin
			key_q   <= key;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.wr_add) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_comb begin
		case (cmd.res)
			RES_ADD: count_res = count_q + CW'(1);
			RES_DEL: count_res = count_q - CW'(1);
			default: count_res = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			entry_count <= CountWidth'(count_res);
			last        <= cmd.last;
			case (cmd.res)
				RES_ADD: begin
					status      <= ST_OK;
					found_key   <= key_q;
					found_value <= value_q;
				end
				RES_FULL: begin
					status      <= ST_FULL;
					found_key   <= '0;
					found_value <= '0;
				end
				RES_EMPTY: begin
					status      <= ST_EMPTY;
					found_key   <= '0;
					found_value <= '0;
				end
				RES_READ, RES_DEL: begin
					status      <= ST_OK;
					found_key   <= rd_data_s1.key;
					found_value <= rd_data_s1.value;
				end
				RES_UPD: begin
					status      <= ST_OK;
					found_key   <= rd_data_s1.key;
					found_value <= value_q;
				end
				default: begin
					status      <= ST_NOTFOUND;
					found_key   <= '0;
					found_value <= '0;
				end
			endcase
		end
	end

endmodule

// ===== design/krt_checker.sv =====
module krt_checker import krt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic [2:0]            op,
	input logic                  strobe,
	input logic [1:0]            status,
	input logic [CountWidth-1:0] entry_count,
	input logic                  last
);

	// a list streams without gaps until its final word
	a_list_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("list stream broke before last word");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final word shown while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == OP_ADD || op == OP_SEARCH || op == OP_UPDATE ||
		op == OP_DELETE || op == OP_LIST) |=> busy)
		else $error("valid op accepted without going busy");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == ST_EMPTY |-> entry_count == '0 && last)
		else $error("empty report with entries or not last");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == ST_FULL |-> entry_count == CountWidth'(DEPTH))
		else $error("full report below depth");

endmodule

bind keyed_record_table krt_checker #(
	.DEPTH (DEPTH)
) u_krt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.op          (op),
	.strobe      (strobe),
	.status      (status),
	.entry_count (entry_count),
	.last        (last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import krt_pkg::*;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 160;
	localparam int MAX_PRINTS = 60;

	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	localparam logic signed [KeyWidth-1:0] KEY_MIN = {1'b1, {(KeyWidth-1){1'b0}}};
	localparam logic signed [KeyWidth-1:0] KEY_MAX = {1'b0, {(KeyWidth-1){1'b1}}};
	localparam logic [ValueWidth-1:0] VAL_MAX = {ValueWidth{1'b1}};

	typedef struct packed {
		status_t                     status;
		logic signed [KeyWidth-1:0]  fkey;
		logic [ValueWidth-1:0]       fval;
		logic [CountWidth-1:0]       count;
		logic                        lst;
	} reply_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [2:0]                   op;
	logic signed [KeyWidth-1:0]   key;
	logic [ValueWidth-1:0]        value;
	logic                         strobe;
	logic [1:0]                   status;
	logic signed [KeyWidth-1:0]   found_key;
	logic [ValueWidth-1:0]        found_value;
	logic [CountWidth-1:0]        entry_count;
	logic                         last;

	// shadow copy of the table contents
	logic signed [KeyWidth-1:0]   tbl_key [DEPTH];
	logic [ValueWidth-1:0]        tbl_val [DEPTH];
	int                           tbl_fill;

	reply_t                       due_words[$];
	reply_t                       want;
	logic signed [KeyWidth-1:0]   key_pool [12];
	int                           idle_pct;
	int                           errors;
	int                           cycle_count;

	keyed_record_table #(.DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.key(key),
		.value(value),
		.strobe(strobe),
		.status(status),
		.found_key(found_key),
		.found_value(found_value),
		.entry_count(entry_count),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void queue_reply(input status_t st, input logic signed [KeyWidth-1:0] k,
			input logic [ValueWidth-1:0] v, input logic lst);
		reply_t r;
		r.status = st;
		r.fkey   = k;
		r.fval   = v;
		r.count  = tbl_fill[CountWidth-1:0];
		r.lst    = lst;
		due_words.push_back(r);
	endfunction

	// apply one accepted word to the shadow table and queue its replies
	function automatic void table_apply(input logic [2:0] opc, input logic signed [KeyWidth-1:0] k,
			input logic [ValueWidth-1:0] v);
		int hit;
		logic signed [KeyWidth-1:0] dk;
		logic [ValueWidth-1:0] dv;
		hit = -1;
		for (int i = 0; i < tbl_fill; i++)
			if (hit < 0 && tbl_key[i] == k)
				hit = i;
		case (opc)
			OP_ADD: begin
				if (tbl_fill >= DEPTH) begin
					queue_reply(ST_FULL, '0, '0, 1'b1);
				end else begin
					tbl_key[tbl_fill] = k;
					tbl_val[tbl_fill] = v;
					tbl_fill++;
					queue_reply(ST_OK, k, v, 1'b1);
				end
			end
			OP_SEARCH: begin
				if (hit < 0)
					queue_reply(ST_NOTFOUND, '0, '0, 1'b1);
				else
					queue_reply(ST_OK, tbl_key[hit], tbl_val[hit], 1'b1);
			end
			OP_UPDATE: begin
				if (hit < 0) begin
					queue_reply(ST_NOTFOUND, '0, '0, 1'b1);
				end else begin
					tbl_val[hit] = v;
					queue_reply(ST_OK, tbl_key[hit], tbl_val[hit], 1'b1);
				end
			end
			OP_DELETE: begin
				if (hit < 0) begin
					queue_reply(ST_NOTFOUND, '0, '0, 1'b1);
				end else begin
					dk = tbl_key[hit];
					dv = tbl_val[hit];
					// close the gap left by the removed entry
					for (int j = hit; j + 1 < tbl_fill; j++) begin
						tbl_key[j] = tbl_key[j+1];
						tbl_val[j] = tbl_val[j+1];
					end
					tbl_fill--;
					queue_reply(ST_OK, dk, dv, 1'b1);
				end
			end
			OP_LIST: begin
				if (tbl_fill == 0)
					queue_reply(ST_EMPTY, '0, '0, 1'b1);
				else
					for (int i = 0; i < tbl_fill; i++)
						queue_reply(ST_OK, tbl_key[i], tbl_val[i], i + 1 == tbl_fill);
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (errors < MAX_PRINTS)
			$display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
		errors++;
	endtask

	// drive one word and hold it until the block takes it
	task automatic send_word(input logic [2:0] opc, input logic signed [KeyWidth-1:0] k,
			input logic [ValueWidth-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		op    <= opc;
		key   <= k;
		value <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		table_apply(opc, k, v);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	function automatic logic signed [KeyWidth-1:0] pick_key();
		if ($urandom_range(99) < 80)
			return key_pool[$urandom_range(11)];
		return $urandom;
	endfunction

	function automatic logic [ValueWidth-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return VAL_MAX;
		return ValueWidth'($urandom_range(65535));
	endfunction

	task automatic test_empty_table();
		idle_pct = 0;
		send_word(OP_LIST, 32'sd5, 16'd1);
		send_word(OP_SEARCH, 32'sd5, 16'd2);
		send_word(OP_UPDATE, 32'sd5, 16'd3);
		send_word(OP_DELETE, 32'sd5, 16'd4);
	endtask

	task automatic test_extreme_keys();
		send_word(OP_ADD, KEY_MIN, 16'd0);
		send_word(OP_ADD, KEY_MAX, VAL_MAX);
		send_word(OP_ADD, 32'sd0, 16'd1234);
		send_word(OP_SEARCH, KEY_MIN, 16'd9);
		send_word(OP_SEARCH, KEY_MAX, 16'd9);
		send_word(OP_UPDATE, KEY_MAX, 16'd0);
		send_word(OP_LIST, 32'sd0, 16'd0);
	endtask

	task automatic test_duplicate_keys();
		send_word(OP_ADD, 32'sd0, 16'd5);
		send_word(OP_SEARCH, 32'sd0, 16'd0);
		send_word(OP_UPDATE, 32'sd0, 16'd777);
		send_word(OP_DELETE, 32'sd0, 16'd0);
		send_word(OP_SEARCH, 32'sd0, 16'd0);
		send_word(OP_SEARCH, 32'sd42, 16'd0);
		send_word(OP_UPDATE, 32'sd42, VAL_MAX);
		send_word(OP_DELETE, 32'sd42, 16'd0);
		send_word(OP_DELETE, KEY_MIN, 16'd0);
		send_word(OP_LIST, 32'sd0, 16'd0);
	endtask

	task automatic test_unused_ops();
		send_word(OP_SPARE_5, KEY_MAX, VAL_MAX);
		send_word(OP_SPARE_6, 32'sd0, 16'd0);
		send_word(OP_SPARE_7, KEY_MIN, 16'h5a5a);
		send_word(OP_SEARCH, 32'sd0, 16'd0);
	endtask

	task automatic test_fill_to_full();
		idle_pct = 0;
		repeat (DEPTH + 2)
			send_word(OP_ADD, pick_key(), pick_value());
		send_word(OP_LIST, 32'sd0, 16'd0);
	endtask

	task automatic test_random_mix(input int n, input int gap_pct, input int add_pct);
		int r;
		logic [2:0] opc;
		idle_pct = gap_pct;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < add_pct) begin
				opc = OP_ADD;
			end else begin
				r = $urandom_range(99);
				if (r < 28)
					opc = OP_SEARCH;
				else if (r < 52)
					opc = OP_UPDATE;
				else if (r < 80)
					opc = OP_DELETE;
				else if (r < 93)
					opc = OP_LIST;
				else
					opc = OP_SPARE_5 + 3'($urandom_range(2));
			end
			send_word(opc, pick_key(), pick_value());
		end
	endtask

	task automatic test_drain_to_empty();
		idle_pct = 23;
		while (tbl_fill > 0)
			send_word(OP_DELETE, tbl_key[$urandom_range(tbl_fill - 1)], pick_value());
		send_word(OP_LIST, pick_key(), pick_value());
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (due_words.size() == 0) begin
				report_mismatch("unexpected word", 64'd0,
					64'({status, found_key, found_value}));
			end else begin
				want = due_words.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(want.status), 64'(status));
				if (found_key !== want.fkey)
					report_mismatch("found_key", 64'(want.fkey), 64'(found_key));
				if (found_value !== want.fval)
					report_mismatch("found_value", 64'(want.fval), 64'(found_value));
				if (entry_count !== want.count)
					report_mismatch("entry_count", 64'(want.count), 64'(entry_count));
				if (last !== want.lst)
					report_mismatch("last", 64'(want.lst), 64'(last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		op          = '0;
		key         = '0;
		value       = '0;
		tbl_fill    = 0;
		idle_pct    = 0;
		errors      = 0;
		cycle_count = 0;
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < 12; i++)
			key_pool[i] = $urandom;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_extreme_keys();
		test_duplicate_keys();
		test_unused_ops();
		test_fill_to_full();
		test_random_mix(45, 0, 30);
		test_random_mix(45, 77, 45);
		test_random_mix(45, 23, 35);
		test_random_mix(20, 0, 10);
		test_drain_to_empty();

		@(negedge clk);
		start <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		// delete may still be shifting after its word
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
